@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion helper macros; compiled out when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that a property holds at each rising edge outside reset.
`define ASSERT_HOLD(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_HOLD(lbl, clk, rst, prop)
`define ASSERT_IMPL(lbl, clk, rst, ante, cons)
`endif
`endif

@@ rtl/pa_pkg.sv @@
// ---------------------------------------------------------------------------
// pa_pkg
// Shared constants and controller/datapath interface types.
// ---------------------------------------------------------------------------
package pa_pkg;
  localparam int MAX_NODES   = 4096;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int MAX_LINKS   = 16;
  localparam int LINK_W      = $clog2(MAX_LINKS + 1);
  localparam int PICK_W      = (MAX_LINKS > 1) ? $clog2(MAX_LINKS) : 1;
  localparam int DEG_W       = 13;
  localparam int TOT_W       = 18;
  localparam int DRAW_W      = 31;
  localparam int NCFG_W      = 13;
  localparam int LCFG_W      = 5;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;
  localparam int SEED_EXTRA  = 10;
  localparam int SEED_DEGREE = 2;
  localparam int MIN_NODES   = 10;

  localparam logic CMD_INIT = 1'b0;
  localparam logic CMD_DRAW = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_NODE_COUNT = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_LINKS      = 1'b1;

  typedef struct packed {
    logic init_start;
    logic init_step;
    logic mod_start;
    logic walk_start;
    logic walking;
    logic emit_rd;
    logic emit_wr;
    logic emit_cur;
    logic fin_strobe;
  } ctrl_cmd_t;

  typedef struct packed {
    logic gen_done;
    logic init_end;
    logic mod_done;
    logic walk_hit;
    logic walk_miss;
    logic last_pick;
    logic edge_last;
  } dp_stat_t;
endpackage

@@ rtl/preferential_attachment_edge_generator.sv @@
// ---------------------------------------------------------------------------
// preferential_attachment_edge_generator
// Scale-free graph growth: weighted node picks and edge emission.
// ---------------------------------------------------------------------------
// Usage:
//   Raise start with cmd and random_draw while busy is low; the item is
//   taken at that edge and busy rises the next cycle until the item is done.
//   cmd = init latches node_count and links_per_node (clamped), writes the
//   seed degrees one node a cycle and emits nothing.
//   cmd = draw reduces random_draw modulo the total degree, then walks
//   the degree store one node per cycle up to the current node. The last
//   of links_per_node picks emits an edge to each pick, reading then bumping
//   its degree; a closing step sets the new node's degree and ends its run.
//   A draw while finished gives one status result.
//   Results sit on the result ports for one cycle each, marked by strobe;
//   the receiver cannot stall them.
//   Configuration writes (cfg_valid, always ready) take effect at the next
//   init. Reset leaves the block finished with no clearing pass.
// ---------------------------------------------------------------------------
module preferential_attachment_edge_generator
  import pa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic                  cmd,
  input  logic [DRAW_W-1:0]     random_draw,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic [NODE_W-1:0]     new_node,
  output logic [NODE_W-1:0]     old_node,
  output logic                  last_edge,
  output logic                  status
);
  ctrl_cmd_t ctl;
  dp_stat_t  stat;

  // Sequence each item through init, modulo, walk and emit phases.
  pa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy)
  );

  // Hold degrees, picks and counters; drive the result registers.
  pa_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .stat        (stat),
    .random_draw (random_draw),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .strobe      (strobe),
    .new_node    (new_node),
    .old_node    (old_node),
    .last_edge   (last_edge),
    .status      (status)
  );
endmodule

@@ rtl/pa_mod.sv @@
// ---------------------------------------------------------------------------
// pa_mod
// Restoring remainder unit, one dividend bit per cycle.
// ---------------------------------------------------------------------------
module pa_mod
  import pa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [DRAW_W-1:0] dividend,
  input  logic [TOT_W-1:0]  divisor,
  output logic              done,
  output logic [TOT_W-1:0]  remainder
);
  localparam int STEP_W = $clog2(DRAW_W + 1);

  logic [STEP_W-1:0] steps;
  logic [DRAW_W-1:0] dvd;
  logic [TOT_W:0]    shifted;

  assign shifted = {remainder, dvd[DRAW_W-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        steps <= STEP_W'(DRAW_W);
      end else if (steps != '0) begin
        steps <= steps - 1'b1;
        done  <= (steps == STEP_W'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      remainder <= '0;
      dvd       <= dividend;
    end else if (steps != '0) begin
      dvd <= {dvd[DRAW_W-2:0], 1'b0};
      if (shifted >= {1'b0, divisor}) begin
        remainder <= TOT_W'(shifted - {1'b0, divisor});
      end else begin
        remainder <= shifted[TOT_W-1:0];
      end
    end
  end
endmodule

@@ rtl/pa_ctrl.sv @@
// ---------------------------------------------------------------------------
// pa_ctrl
// Sequencer for init sweeps, draws, degree walks and edge emission.
// ---------------------------------------------------------------------------
module pa_ctrl
  import pa_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic      cmd,
  input  dp_stat_t  stat,
  output ctrl_cmd_t ctl,
  output logic      busy
);
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_EMRD  = 3'd4;
  localparam logic [2:0] S_EMWR  = 3'd5;
  localparam logic [2:0] S_EMCUR = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state, state_next;

  assign busy = (state != S_IDLE);

  always_comb begin
    ctl        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (cmd == CMD_INIT) begin
            ctl.init_start = 1'b1;
            state_next     = S_INIT;
          end else if (stat.gen_done) begin
            state_next = S_FIN;
          end else begin
            ctl.mod_start = 1'b1;
            state_next    = S_MOD;
          end
        end
      end
      S_INIT: begin
        ctl.init_step = 1'b1;
        if (stat.init_end) state_next = S_IDLE;
      end
      S_MOD: begin
        if (stat.mod_done) begin
          ctl.walk_start = 1'b1;
          state_next     = S_WALK;
        end
      end
      S_WALK: begin
        ctl.walking = 1'b1;
        if (stat.walk_hit) state_next = stat.last_pick ? S_EMRD : S_IDLE;
        else if (stat.walk_miss) state_next = S_IDLE;
      end
      S_EMRD: begin
        ctl.emit_rd = 1'b1;
        state_next  = S_EMWR;
      end
      S_EMWR: begin
        ctl.emit_wr = 1'b1;
        state_next  = stat.edge_last ? S_EMCUR : S_EMRD;
      end
      S_EMCUR: begin
        ctl.emit_cur = 1'b1;
        state_next   = S_IDLE;
      end
      S_FIN: begin
        ctl.fin_strobe = 1'b1;
        state_next     = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end
endmodule

@@ rtl/pa_dp.sv @@
// ---------------------------------------------------------------------------
// pa_dp
// Degree store, pick list, counters, remainder unit and result registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module pa_dp
  import pa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_cmd_t             ctl,
  output dp_stat_t              stat,
  input  logic [DRAW_W-1:0]     random_draw,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  strobe,
  output logic [NODE_W-1:0]     new_node,
  output logic [NODE_W-1:0]     old_node,
  output logic                  last_edge,
  output logic                  status
);
  logic [NCFG_W-1:0] cfg_nodes;
  logic [LCFG_W-1:0] cfg_links;
  logic [CNT_W-1:0]  eff_n;
  logic [LINK_W-1:0] eff_m;
  logic [CNT_W-1:0]  n_sat, seeds;
  logic [LINK_W-1:0] m_sat;

  logic [DEG_W-1:0]  deg_mem [MAX_NODES];
  logic [NODE_W-1:0] rd_addr, wr_addr;
  logic [DEG_W-1:0]  rd_data, wr_data;
  logic              we;

  logic [NODE_W-1:0] pick_list [MAX_LINKS];
  logic [LINK_W-1:0] picks_made, edge_j;
  logic [TOT_W-1:0]  total, hit, sum, cand, rem;
  logic [CNT_W-1:0]  cur, init_k, walk_addr, rd_idx;
  logic              finished, rd_valid, picked, mod_done;
  logic [NODE_W-1:0] edge_dst;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_nodes <= NCFG_W'(100);
      cfg_links <= LCFG_W'(2);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_COUNT: cfg_nodes <= cfg_data;
        REG_LINKS:      cfg_links <= cfg_data[LCFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the register values into their legal ranges at init.
  always_comb begin
    if (cfg_links == '0) m_sat = LINK_W'(1);
    else if (32'(cfg_links) > MAX_LINKS) m_sat = LINK_W'(MAX_LINKS);
    else m_sat = LINK_W'(cfg_links);
    if (32'(cfg_nodes) < MIN_NODES) n_sat = CNT_W'(MIN_NODES);
    else if (32'(cfg_nodes) > MAX_NODES) n_sat = CNT_W'(MAX_NODES);
    else n_sat = CNT_W'(cfg_nodes);
    seeds = CNT_W'(m_sat) + CNT_W'(SEED_EXTRA);
    if (seeds > n_sat) seeds = n_sat;
  end

  pa_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .go        (ctl.mod_start),
    .dividend  (random_draw),
    .divisor   (total),
    .done      (mod_done),
    .remainder (rem)
  );

  assign edge_dst = pick_list[edge_j[PICK_W-1:0]];
  assign cand     = sum + TOT_W'(rd_data);

  always_comb begin
    picked = 1'b0;
    for (int j = 0; j < MAX_LINKS; j++) begin
      if ((LINK_W'(j) < picks_made) && (CNT_W'(pick_list[j]) == rd_idx)) picked = 1'b1;
    end
  end

  always_comb begin
    stat.gen_done  = finished || (total == '0) || (32'(cur) >= MAX_NODES);
    stat.init_end  = (init_k + 1'b1) >= cur;
    stat.mod_done  = mod_done;
    stat.walk_hit  = ctl.walking && rd_valid && (rd_idx < cur) && (cand > hit) && !picked;
    stat.walk_miss = ctl.walking && rd_valid && (rd_idx >= cur);
    stat.last_pick = (picks_made + 1'b1) >= eff_m;
    stat.edge_last = (edge_j + 1'b1) == eff_m;
  end

  // Memory port selection.
  always_comb begin
    rd_addr = ctl.emit_rd ? edge_dst : walk_addr[NODE_W-1:0];
    we      = ctl.init_step || ctl.emit_wr || ctl.emit_cur;
    wr_addr = edge_dst;
    wr_data = rd_data + 1'b1;
    if (ctl.init_step) begin
      wr_addr = init_k[NODE_W-1:0];
      wr_data = DEG_W'(SEED_DEGREE);
    end else if (ctl.emit_cur) begin
      wr_addr = cur[NODE_W-1:0];
      wr_data = DEG_W'(eff_m);
    end
  end

  always_ff @(posedge clk) begin
    if (we) deg_mem[wr_addr] <= wr_data;
    rd_data <= deg_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      eff_n      <= CNT_W'(100);
      eff_m      <= LINK_W'(2);
      finished   <= 1'b1;
      total      <= '0;
      cur        <= '0;
      picks_made <= '0;
      edge_j     <= '0;
      rd_valid   <= 1'b0;
    end else begin
      if (ctl.init_start) begin
        eff_n      <= n_sat;
        eff_m      <= m_sat;
        total      <= TOT_W'({seeds, 1'b0});
        cur        <= seeds;
        finished   <= seeds >= n_sat;
        picks_made <= '0;
        edge_j     <= '0;
      end
      if (ctl.walk_start) rd_valid <= 1'b0;
      else if (ctl.walking) rd_valid <= 1'b1;
      if (stat.walk_hit) picks_made <= picks_made + 1'b1;
      if (ctl.emit_wr) begin
        total  <= total + TOT_W'(SEED_DEGREE);
        edge_j <= edge_j + 1'b1;
      end
      if (ctl.emit_cur) begin
        cur        <= cur + 1'b1;
        picks_made <= '0;
        edge_j     <= '0;
        finished   <= (cur + 1'b1) >= eff_n;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init_start) init_k <= '0;
    else if (ctl.init_step) init_k <= init_k + 1'b1;
    if (ctl.walk_start) begin
      hit       <= rem;
      sum       <= '0;
      walk_addr <= '0;
    end else if (ctl.walking) begin
      walk_addr <= walk_addr + 1'b1;
      rd_idx    <= walk_addr;
      if (rd_valid) sum <= cand;
    end
    if (stat.walk_hit) pick_list[picks_made[PICK_W-1:0]] <= rd_idx[NODE_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) strobe <= 1'b0;
    else     strobe <= ctl.emit_wr || ctl.fin_strobe;
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_wr) begin
      new_node  <= cur[NODE_W-1:0];
      old_node  <= edge_dst;
      last_edge <= stat.edge_last;
      status    <= 1'b0;
    end else if (ctl.fin_strobe) begin
      new_node  <= '0;
      old_node  <= '0;
      last_edge <= 1'b0;
      status    <= 1'b1;
    end
  end

  `ASSERT_IMPL(a_edge_older, clk, rst, strobe && !status, old_node < new_node)
  `ASSERT_IMPL(a_fin_zero, clk, rst, strobe && status, (new_node == '0) && (old_node == '0) && !last_edge)
  `ASSERT_HOLD(a_picks_bound, clk, rst, picks_made <= eff_m)
endmodule
